FILE: rtl/rld_pkg.sv
// Package for the row lead delay line: controller states, command and status structs,
// and the int64 to float64 conversion function. No dependencies.
`default_nettype none
package rld_pkg;

    localparam logic [1:0] KIND_INT64 = 2'd0;
    localparam logic [1:0] KIND_FLOAT = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;    // Append the incoming row (no result).
        logic emit;     // Emit the oldest row with the incoming lead value.
        logic drain;    // Emit the oldest row as a flush result.
        logic clear;    // Reset pointer and count after a drain.
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;     // Output register holds an untaken result.
        logic out_take;     // Output register is being emptied this cycle.
        logic held_zero;    // No rows held.
        logic held_lt_off;  // Fewer rows held than the effective offset.
        logic held_one;     // Exactly one row held.
    } t_status;

    // Signed 64-bit integer to IEEE double, round to nearest even.
    function automatic logic [63:0] int_to_double(input logic [63:0] raw);
        logic        sgn;
        logic [63:0] mag;
        logic [63:0] norm;
        logic [6:0]  lz;
        logic [10:0] expo;
        logic [52:0] mant;
        logic        guard;
        logic        sticky;
        logic        rnd;
        logic [53:0] sum;
        sgn = raw[63];
        mag = sgn ? (~raw + 64'd1) : raw;
        lz = 7'd64;
        for (int i = 0; i < 64; i++) begin
            if (mag[i]) begin
                lz = 7'(63 - i);
            end
        end
        norm = mag << lz[5:0];
        mant = norm[63:11];
        guard = norm[10];
        sticky = |norm[9:0];
        rnd = guard & (sticky | mant[0]);
        sum = {1'b0, mant} + {53'd0, rnd};
        expo = 11'(1023 + 63) - {4'd0, lz};
        if (sum[53]) begin
            expo = expo + 11'd1;
        end
        if (mag == 64'd0) begin
            int_to_double = 64'd0;
        end else if (sum[53]) begin
            int_to_double = {sgn, expo, 52'd0};
        end else begin
            int_to_double = {sgn, expo, sum[51:0]};
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/rld_ctrl.sv
// Controller of the row lead delay line: accepts transactions and sequences flush drains.
// Depends on rld_pkg.
`default_nettype none
module rld_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  wire              i_mode,
    output logic             o_ready,
    input  wire rld_pkg::t_status i_status,
    output rld_pkg::t_cmd    o_cmd
);

    rld_pkg::t_state r_state;
    rld_pkg::t_state n_state;
    logic            w_out_free;
    logic            w_acc;

    assign w_out_free = !i_status.out_busy || i_status.out_take;
    assign w_acc      = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rld_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rld_pkg::ST_IDLE: begin
                if (w_acc && i_mode && !i_status.held_zero) begin
                    n_state = rld_pkg::ST_DRAIN;
                end
            end
            rld_pkg::ST_DRAIN: begin
                if (w_out_free && i_status.held_one) begin
                    n_state = rld_pkg::ST_IDLE;
                end
            end
            default: n_state = rld_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            rld_pkg::ST_IDLE: begin
                // Storing never produces a result, so only emits and flushes wait on the output.
                o_ready = w_out_free || (!i_mode && i_status.held_lt_off);
                if (w_acc && !i_mode) begin
                    o_cmd.store = i_status.held_lt_off;
                    o_cmd.emit  = !i_status.held_lt_off;
                end
            end
            rld_pkg::ST_DRAIN: begin
                if (w_out_free) begin
                    o_cmd.drain = 1'b1;
                    o_cmd.clear = i_status.held_one;
                end
            end
            default: ;
        endcase
    end

    a_drain_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rld_pkg::ST_DRAIN |-> !o_ready)
        else $error("input accepted during drain");
    a_drain_has_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rld_pkg::ST_DRAIN |-> !i_status.held_zero)
        else $error("drain with no rows held");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.store, o_cmd.emit, o_cmd.drain}))
        else $error("conflicting commands");

endmodule
`default_nettype wire

FILE: rtl/rld_dpath.sv
// Datapath of the row lead delay line: ring store, pointer and count, conversion, and
// the output register. Depends on rld_pkg.
`default_nettype none
module rld_dpath #(
    parameter int MAX_OFFSET   = 16,
    parameter int PAYLOAD_BITS = 64
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire  [4:0]              i_cfg_data,
    input  wire  [PAYLOAD_BITS-1:0] i_payload,
    input  wire  [63:0]             i_lead_value,
    input  wire  [1:0]              i_value_kind,
    input  wire                     i_value_null,
    input  wire rld_pkg::t_cmd      i_cmd,
    output rld_pkg::t_status        o_status,
    input  wire                     i_out_ready,
    output logic                    o_out_valid,
    output logic [PAYLOAD_BITS-1:0] o_out_payload,
    output logic [63:0]             o_lead_bits,
    output logic                    o_lead_null,
    output logic                    o_last
);

    localparam int AW = (MAX_OFFSET > 1) ? $clog2(MAX_OFFSET) : 1;
    localparam int CW = $clog2(MAX_OFFSET + 1);

    logic [PAYLOAD_BITS-1:0] r_mem [MAX_OFFSET];
    logic [4:0]              r_offset;
    logic [AW-1:0]           r_oldest;
    logic [CW-1:0]           r_held;
    logic [CW-1:0]           w_eff;
    logic [AW-1:0]           w_wslot;
    logic [AW-1:0]           w_onext;
    logic [63:0]             w_bits;

    // Every index sum stays below twice the depth, so one subtract wraps it.
    function automatic logic [AW-1:0] wrap(input logic [CW:0] v);
        logic [CW:0] m;
        m = (v >= (CW+1)'(MAX_OFFSET)) ? v - (CW+1)'(MAX_OFFSET) : v;
        wrap = m[AW-1:0];
    endfunction

    always_comb begin
        if (r_offset == 5'd0) begin
            w_eff = CW'(1);
        end else if ({27'd0, r_offset} > MAX_OFFSET) begin
            w_eff = CW'(MAX_OFFSET);
        end else begin
            w_eff = CW'(r_offset);
        end
    end

    assign w_onext = wrap({{(CW+1-AW){1'b0}}, r_oldest} + (CW+1)'(1));
    assign w_wslot = i_cmd.emit
        ? wrap({{(CW+1-AW){1'b0}}, w_onext} + {1'b0, r_held} - (CW+1)'(1))
        : wrap({{(CW+1-AW){1'b0}}, r_oldest} + {1'b0, r_held});

    always_comb begin
        case (i_value_kind)
            rld_pkg::KIND_INT64: w_bits = rld_pkg::int_to_double(i_lead_value);
            rld_pkg::KIND_FLOAT: w_bits = i_lead_value;
            default:             w_bits = 64'd0;
        endcase
        if (i_value_null) begin
            w_bits = 64'd0;
        end
    end

    assign o_status.out_busy    = o_out_valid;
    assign o_status.out_take    = o_out_valid && i_out_ready;
    assign o_status.held_zero   = r_held == '0;
    assign o_status.held_lt_off = r_held < w_eff;
    assign o_status.held_one    = r_held == CW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.store || i_cmd.emit) begin
            r_mem[w_wslot] <= i_payload;
        end
        if (i_cmd.emit || i_cmd.drain) begin
            o_out_payload <= r_mem[r_oldest];
            o_lead_bits   <= i_cmd.emit ? w_bits : 64'd0;
            o_lead_null   <= i_cmd.emit ? i_value_null : 1'b1;
            o_last        <= i_cmd.emit ? 1'b1 : (r_held == CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= 5'd1;
            r_oldest    <= '0;
            r_held      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_offset <= i_cfg_data;
            end
            if (i_cmd.store) begin
                r_held <= r_held + CW'(1);
            end
            if (i_cmd.emit) begin
                r_oldest <= w_onext;
            end
            if (i_cmd.drain) begin
                r_oldest <= i_cmd.clear ? '0 : w_onext;
                r_held   <= r_held - CW'(1);
            end
            if (i_cmd.emit || i_cmd.drain) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CW'(MAX_OFFSET))
        else $error("held count above store depth");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || i_cmd.drain) && o_out_valid |-> i_out_ready)
        else $error("result overwritten before taken");
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> r_held == '0 && r_oldest == '0)
        else $error("drain end did not empty the store");

endmodule
`default_nettype wire

FILE: rtl/row_lead_delay_line.sv
// Top level of the row lead delay line: lead window function over a row stream.
// Depends on rld_pkg, rld_ctrl and rld_dpath.
//
//  channel   | direction | handshake           | contents
//  ----------+-----------+---------------------+---------------------------------------
//  s_axis    | in        | tvalid/tready       | rows and flush requests
//  m_axis    | out       | tvalid/tready       | older row with lead value
//  cfg       | in        | i_cfg_we            | lead_offset
//
// A data row makes one store write and, when it emits a result, one store read. A flush
// that finds N rows held is accepted, then gives one result per cycle out of the ring
// store read port while the output does not stall, and blocks input until the last one is
// issued. Reset is synchronous and active low; it clears the pointer, the count, the output
// valid and the offset (back to 1) but not the store contents.
// The output register lets a new row be accepted in the same cycle that a waiting result
// is taken; a stall on the output holds any flush and any row that would produce a result.
`default_nettype none
module row_lead_delay_line #(
    parameter int MAX_OFFSET   = 16,
    parameter int PAYLOAD_BITS = 64
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire  [4:0]   i_cfg_data,      // lead_offset
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: row_payload[63:0], lead_value[127:64], value_kind[129:128],
    // value_null[130], zeros to bit 135.
    input  wire  [135:0] s_axis_tdata,
    input  wire          s_axis_tuser,    // mode
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // tdata: out_payload[63:0], lead_bits[127:64], lead_null[128], zeros to bit 135.
    output logic [135:0] m_axis_tdata,
    output logic         m_axis_tlast     // last
);

    rld_pkg::t_cmd           w_cmd;
    rld_pkg::t_status        w_status;
    logic [PAYLOAD_BITS-1:0] w_out_payload;
    logic [63:0]             w_lead_bits;
    logic                    w_lead_null;

    rld_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_mode   (s_axis_tuser),
        .o_ready  (s_axis_tready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    rld_dpath #(
        .MAX_OFFSET   (MAX_OFFSET),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_payload     (s_axis_tdata[PAYLOAD_BITS-1:0]),
        .i_lead_value  (s_axis_tdata[127:64]),
        .i_value_kind  (s_axis_tdata[129:128]),
        .i_value_null  (s_axis_tdata[130]),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_payload (w_out_payload),
        .o_lead_bits   (w_lead_bits),
        .o_lead_null   (w_lead_null),
        .o_last        (m_axis_tlast)
    );

    // The payload is zero-extended into its 64-bit slot.
    assign m_axis_tdata = {7'd0, w_lead_null, w_lead_bits,
                           64'(w_out_payload)};

endmodule
`default_nettype wire

FILE: verif/tb_row_lead_delay_line.sv
// Self-checking testbench for row_lead_delay_line: directed rows, then random rows and flushes
// under several lead offsets, with random idling on both stream sides.
// Depends on rld_pkg and the RTL of row_lead_delay_line only.
`timescale 1ns / 100ps
`default_nettype none
module tb_row_lead_delay_line;

    localparam int DEPTH = 16;
    localparam int SETTLE_CYCLES = 24;     // Longer than the longest flush drain.
    localparam int STALL_LIMIT = 3000;     // Cycles with no transaction before giving up.
    localparam int HOLD_CYCLES = 120;      // Long receiver hold-off.
    localparam int RAND_ITEMS = 36;        // Random rows per offset phase.

    localparam bit MODE_DATA = 1'b0;
    localparam bit MODE_FLUSH = 1'b1;
    localparam logic [1:0] KIND_INT64 = rld_pkg::KIND_INT64;
    localparam logic [1:0] KIND_FLOAT = rld_pkg::KIND_FLOAT;
    localparam logic [1:0] KIND_OTHER = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // One emitted row with its lead value.
    typedef struct {
        logic [63:0] payload;
        logic [63:0] bits;
        logic        is_null;
        logic        last;
    } t_lead_row;

    // One directed stimulus row; typed marks an expectation written out by hand.
    typedef struct {
        logic        mode;
        logic [63:0] payload;
        logic [63:0] lead;
        logic [1:0]  kind;
        logic        is_null;
        bit          typed;
        t_lead_row   want;
    } t_stim_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [4:0]   i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;
    logic         m_axis_tlast;

    row_lead_delay_line u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the block's state, updated on every accepted input transaction.
    logic [63:0] shadow_rows [DEPTH];
    logic [3:0]  shadow_oldest = '0;
    int unsigned shadow_held = 0;
    logic [4:0]  shadow_offset = 5'd1;
    t_lead_row   pending_rows[$];

    int  errors = 0;
    int  rows_sent = 0;
    int  flushes_sent = 0;
    int  results_seen = 0;
    bit  idle_enabled = 1'b1;
    int  hold_requests = 0;     // Raised by the sender side only.
    int  holds_done = 0;        // Advanced by the receiver only.
    int  quiet_cycles = 0;

    // Lead value of a row as float64 bits; ints round to nearest even through real.
    function automatic logic [63:0] lead_as_double(logic [63:0] raw, logic [1:0] kind);
        longint sval;
        real    rval;
        if (kind == KIND_INT64) begin
            sval = raw;
            rval = sval;
            return $realtobits(rval);
        end
        if (kind == KIND_FLOAT) begin
            return raw;
        end
        return 64'd0;
    endfunction

    // Update the shadow state for one accepted item and queue what it will emit.
    task automatic predict_leads(logic mode, logic [63:0] payload, logic [63:0] lead,
                                 logic [1:0] kind, logic is_null);
        int unsigned eff;
        t_lead_row   r;
        int          n;
        eff = (shadow_offset == 0) ? 1 : (shadow_offset > DEPTH) ? DEPTH : shadow_offset;
        if (mode == MODE_FLUSH) begin
            n = 0;
            while (shadow_held > 0 && n < DEPTH) begin
                r.payload = shadow_rows[shadow_oldest];
                shadow_oldest = shadow_oldest + 4'd1;
                shadow_held--;
                r.bits = 64'd0;
                r.is_null = 1'b1;
                r.last = (shadow_held == 0);
                pending_rows.push_back(r);
                n++;
            end
            shadow_oldest = '0;
            shadow_held = 0;
        end else if (shadow_held < eff) begin
            shadow_rows[4'(shadow_oldest + shadow_held)] = payload;
            shadow_held++;
        end else begin
            // Emits the oldest row; held count stays put, even when above the offset.
            r.payload = shadow_rows[shadow_oldest];
            r.bits = is_null ? 64'd0 : lead_as_double(lead, kind);
            r.is_null = is_null;
            r.last = 1'b1;
            shadow_oldest = shadow_oldest + 4'd1;
            shadow_rows[4'(shadow_oldest + shadow_held - 1)] = payload;
            pending_rows.push_back(r);
        end
    endtask

    // Offers one item and waits until the block takes it.
    task automatic send_row(logic mode, logic [63:0] payload, logic [63:0] lead,
                            logic [1:0] kind, logic is_null);
        if (idle_enabled && $urandom_range(99) < 18) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = mode;
        s_axis_tdata = {5'd0, is_null, kind, lead, payload};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_leads(mode, payload, lead, kind, is_null);
        if (mode == MODE_FLUSH) flushes_sent++;
        else rows_sent++;
        @(negedge i_clk);
    endtask

    // Waits until every expected result has come, then for the drain latency.
    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (pending_rows.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Writes lead_offset; only called while the block is idle.
    task automatic write_offset(logic [4:0] value);
        i_cfg_we = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        shadow_offset = value;
    endtask

    // Random row with a spread of lead values; a few flushes mixed in.
    task automatic send_random_row();
        logic [63:0] lead;
        logic [1:0]  kind;
        case ($urandom_range(5))
            0: lead = {$urandom, $urandom};
            1: lead = 64'($signed($urandom_range(2000)) - 1000);
            2: lead = {1'b1, 63'd0} | 64'($urandom_range(3));
            // Integers of 53 bits and more; above 53 bits they may need rounding.
            3: lead = {11'd0, 1'b1, 20'($urandom), $urandom} << $urandom_range(10);
            default: lead = {$urandom, $urandom} >> $urandom_range(63);
        endcase
        kind = ($urandom_range(9) < 6) ? KIND_INT64 : 2'($urandom_range(3));
        if ($urandom_range(99) < 6) begin
            send_row(MODE_FLUSH, {$urandom, $urandom}, lead, kind, 1'($urandom));
        end else begin
            send_row(MODE_DATA, {$urandom, $urandom}, lead, kind, $urandom_range(99) < 15);
        end
    endtask

    // Receiver: random ready, with a long hold-off on request, counted here.
    always @(negedge i_clk) begin
        if (holds_done != hold_requests) begin
            m_axis_tready <= 1'b0;
            if (quiet_cycles == HOLD_CYCLES) begin
                quiet_cycles <= 0;
                holds_done <= holds_done + 1;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end else begin
            m_axis_tready <= !idle_enabled || ($urandom_range(99) >= 18);
        end
    end

    // Output checker: every result transaction is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_lead_row want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_rows.size() == 0) begin
                $error("unexpected result: payload %h", m_axis_tdata[63:0]);
                errors++;
            end else begin
                want = pending_rows.pop_front();
                if (m_axis_tdata[63:0] !== want.payload) begin
                    $error("out_payload: expected %h, got %h", want.payload, m_axis_tdata[63:0]);
                    errors++;
                end
                if (m_axis_tdata[127:64] !== want.bits) begin
                    $error("lead_bits: expected %h, got %h", want.bits, m_axis_tdata[127:64]);
                    errors++;
                end
                if (m_axis_tdata[128] !== want.is_null) begin
                    $error("lead_null: expected %b, got %b", want.is_null, m_axis_tdata[128]);
                    errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either stream ends the run.
    int stall_count = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    function automatic t_stim_row dir_row(logic mode, logic [63:0] p, logic [63:0] lv,
                                          logic [1:0] k, logic n, bit typed,
                                          logic [63:0] wp, logic [63:0] wb, logic wn);
        t_stim_row s;
        s.mode = mode;
        s.payload = p;
        s.lead = lv;
        s.kind = k;
        s.is_null = n;
        s.typed = typed;
        s.want.payload = wp;
        s.want.bits = wb;
        s.want.is_null = wn;
        s.want.last = 1'b1;
        return s;
    endfunction

    t_stim_row directed_rows[$];
    logic [4:0] offset_plan[$];

    initial begin
        // Directed part at the reset offset of one: every data row after the first emits its predecessor.
        directed_rows = '{
            dir_row(MODE_DATA, 64'd0, 64'd0, KIND_INT64, 1'b0, 1'b0, 64'd0, 64'd0, 1'b0),
            dir_row(MODE_DATA, '1, 64'd0, KIND_INT64, 1'b0, 1'b1, 64'd0, 64'd0, 1'b0),
            dir_row(MODE_DATA, 64'd5, 64'd1, KIND_INT64, 1'b0, 1'b1,
                    '1, 64'h3FF0000000000000, 1'b0),
            dir_row(MODE_DATA, 64'd6, '1, KIND_INT64, 1'b0, 1'b1,
                    64'd5, 64'hBFF0000000000000, 1'b0),
            dir_row(MODE_DATA, 64'd7, 64'h8000000000000000, KIND_INT64, 1'b0, 1'b1,
                    64'd6, 64'hC3E0000000000000, 1'b0),
            dir_row(MODE_DATA, 64'd8, 64'h7FFFFFFFFFFFFFFF, KIND_INT64, 1'b0, 1'b1,
                    64'd7, 64'h43E0000000000000, 1'b0),
            dir_row(MODE_DATA, 64'd9, 64'h123456789ABCDEF0, KIND_FLOAT, 1'b0, 1'b1,
                    64'd8, 64'h123456789ABCDEF0, 1'b0),
            dir_row(MODE_DATA, 64'd10, '1, KIND_OTHER, 1'b0, 1'b1, 64'd9, 64'd0, 1'b0),
            dir_row(MODE_DATA, 64'd11, '1, KIND_UNUSED, 1'b0, 1'b1, 64'd10, 64'd0, 1'b0),
            dir_row(MODE_DATA, 64'd12, 64'd77, KIND_INT64, 1'b1, 1'b1, 64'd11, 64'd0, 1'b1),
            // Ties to even on the rounding of a 54-bit integer.
            dir_row(MODE_DATA, 64'd13, 64'h0020000000000001, KIND_INT64, 1'b0, 1'b0,
                    64'd0, 64'd0, 1'b0),
            dir_row(MODE_DATA, 64'd14, 64'h0020000000000003, KIND_INT64, 1'b0, 1'b0,
                    64'd0, 64'd0, 1'b0),
            dir_row(MODE_FLUSH, '1, '1, KIND_UNUSED, 1'b1, 1'b1, 64'd14, 64'd0, 1'b1),
            // A flush with nothing held gives no result.
            dir_row(MODE_FLUSH, 64'd0, 64'd0, KIND_INT64, 1'b0, 1'b0, 64'd0, 64'd0, 1'b0)
        };
        s_axis_tdata = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            send_row(directed_rows[i].mode, directed_rows[i].payload, directed_rows[i].lead,
                     directed_rows[i].kind, directed_rows[i].is_null);
            if (directed_rows[i].typed) begin
                pending_rows[pending_rows.size() - 1] = directed_rows[i].want;
            end
        end
        wait_drained();

        // Offset lowered while rows are held: the extra rows stay until a flush.
        write_offset(5'd4);
        for (int i = 0; i < 6; i++) send_random_row();
        wait_drained();
        write_offset(5'd2);
        for (int i = 0; i < 3; i++) send_random_row();
        send_row(MODE_FLUSH, '0, '0, KIND_INT64, 1'b0);
        wait_drained();

        // Random phases; zero, the largest legal offset and the largest code are among them.
        offset_plan = '{5'd16, 5'd0, 5'd31, 5'd3, 5'($urandom_range(1, 16)), 5'd1, 5'd8};
        foreach (offset_plan[ph]) begin
            write_offset(offset_plan[ph]);
            idle_enabled = (ph != 5);
            for (int i = 0; i < RAND_ITEMS; i++) begin
                if (ph == 2 && i == 10) begin
                    hold_requests++;        // Receiver stalls while rows keep coming.
                end
                if (ph == 3 && i == 20) begin
                    wait_drained();         // Sender pauses until all results are back.
                end
                send_random_row();
            end
            send_row(MODE_FLUSH, '0, '0, KIND_INT64, 1'b0);
            wait_drained();
        end

        $display("%0d rows and %0d flushes sent, %0d results checked over %0d offset phases.",
                 rows_sent, flushes_sent, results_seen, offset_plan.size() + 3);
        if (errors == 0 && pending_rows.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
